>>> rtl/dssm_pkg.sv
package dssm_pkg;

  // Store geometry
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned WordW = 32;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic signed [WordW-1:0] word_t;
  typedef logic [2:0] op_t;
  typedef logic [1:0] status_t;

  // Operation codes
  localparam op_t OpPush1 = 3'd0;
  localparam op_t OpPush2 = 3'd1;
  localparam op_t OpPop1  = 3'd2;
  localparam op_t OpPop2  = 3'd3;
  localparam op_t OpPeek1 = 3'd4;
  localparam op_t OpPeek2 = 3'd5;

  // Status codes
  localparam status_t StOk        = 2'd0;
  localparam status_t StOverflow  = 2'd1;
  localparam status_t StUnderflow = 2'd2;

  // Store access issued by the pointer unit
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    word_t wdata;
  } mem_req_t;

  // What the response stage needs to finish the item
  typedef struct packed {
    logic    rd;
    status_t status;
  } resp_info_t;

endpackage

>>> rtl/dssm_in_if.sv
interface dssm_in_if;
  logic               valid;
  logic               ready;
  dssm_pkg::op_t      op;
  dssm_pkg::word_t    data;

  modport source (output valid, output op, output data, input ready);
  modport sink   (input valid, input op, input data, output ready);
endinterface

>>> rtl/dssm_out_if.sv
interface dssm_out_if;
  logic                valid;
  logic                ready;
  dssm_pkg::word_t     value;
  dssm_pkg::status_t   status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

>>> rtl/dssm_ram.sv
module dssm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port: write or registered read; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dssm_ptr.sv
module dssm_ptr (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  dssm_pkg::op_t          op_i,
  input  dssm_pkg::word_t        data_i,
  output dssm_pkg::mem_req_t     req_o,
  output dssm_pkg::resp_info_t   info_o
);

  localparam dssm_pkg::cnt_t  DepthCnt = dssm_pkg::cnt_t'(dssm_pkg::DEPTH);
  localparam dssm_pkg::addr_t AddrMax  = dssm_pkg::addr_t'(dssm_pkg::DEPTH - 1);

  dssm_pkg::cnt_t lower_q, lower_d;
  dssm_pkg::cnt_t upper_q, upper_d;
  logic [dssm_pkg::CntW:0] sum;
  logic has_room;
  logic lower_any;
  logic upper_any;

  assign sum       = {1'b0, lower_q} + {1'b0, upper_q};
  assign has_room  = sum < {1'b0, DepthCnt};
  assign lower_any = lower_q != '0;
  assign upper_any = upper_q != '0;

  // Decode the operation into at most one store access and the count moves
  always_comb begin
    lower_d        = lower_q;
    upper_d        = upper_q;
    req_o.we       = 1'b0;
    req_o.re       = 1'b0;
    req_o.addr     = '0;
    req_o.wdata    = data_i;
    info_o.rd      = 1'b0;
    info_o.status  = dssm_pkg::StOk;
    case (op_i)
      dssm_pkg::OpPush1: begin
        if (has_room) begin
          req_o.we   = fire_i;
          req_o.addr = lower_q[dssm_pkg::AddrW-1:0];
          lower_d    = lower_q + 1'b1;
        end else begin
          info_o.status = dssm_pkg::StOverflow;
        end
      end
      dssm_pkg::OpPush2: begin
        if (has_room) begin
          req_o.we   = fire_i;
          req_o.addr = AddrMax - upper_q[dssm_pkg::AddrW-1:0];
          upper_d    = upper_q + 1'b1;
        end else begin
          info_o.status = dssm_pkg::StOverflow;
        end
      end
      dssm_pkg::OpPop1, dssm_pkg::OpPeek1: begin
        if (lower_any) begin
          req_o.re   = fire_i;
          req_o.addr = lower_q[dssm_pkg::AddrW-1:0] - 1'b1;
          info_o.rd  = 1'b1;
          if (op_i == dssm_pkg::OpPop1) begin
            lower_d = lower_q - 1'b1;
          end
        end else begin
          info_o.status = dssm_pkg::StUnderflow;
        end
      end
      dssm_pkg::OpPop2, dssm_pkg::OpPeek2: begin
        if (upper_any) begin
          req_o.re   = fire_i;
          req_o.addr = dssm_pkg::addr_t'(DepthCnt - upper_q);
          info_o.rd  = 1'b1;
          if (op_i == dssm_pkg::OpPop2) begin
            upper_d = upper_q - 1'b1;
          end
        end else begin
          info_o.status = dssm_pkg::StUnderflow;
        end
      end
      default: begin
        info_o.status = dssm_pkg::StOk;
      end
    endcase
  end

  // Advance the stack tops on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
    end else if (fire_i) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

`ifndef SYNTH
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum <= {1'b0, DepthCnt})
    else $error("stacks overlap");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_o.we |=> sum == $past(sum) + 1'b1)
    else $error("push did not grow the stacks by one word");
  a_refused_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && info_o.status != dssm_pkg::StOk |=> $stable(lower_q) && $stable(upper_q))
    else $error("refused operation moved a stack top");
`endif

endmodule

>>> rtl/dual_stack_shared_memory.sv
// Two stacks in one single-port store of DEPTH words; at most one access per item.
// The store read is registered at the input transfer, and the result then goes into
// the output register once that register is free. Throughput: one item per cycle
// while the output is taken, set by the single store port. Reset clears both stack
// tops and the pipeline valids at once; the store itself is not cleared.
module dual_stack_shared_memory (
  input  logic        clk_i,
  input  logic        rst_ni,
  dssm_in_if.sink     in_i,
  dssm_out_if.source  out_o
);

  dssm_pkg::mem_req_t   req;
  dssm_pkg::resp_info_t info;
  dssm_pkg::word_t      rdata;

  logic fire;
  logic adv;
  logic busy_q, busy_d;
  dssm_pkg::resp_info_t info_q;
  logic out_valid_q, out_valid_d;
  dssm_pkg::word_t   value_q;
  dssm_pkg::status_t status_q;

  // The access stage moves on when the output register is free
  assign adv        = busy_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !busy_q || adv;
  assign fire       = in_i.valid && in_i.ready;

  dssm_ptr u_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (in_i.op),
    .data_i (in_i.data),
    .req_o  (req),
    .info_o (info)
  );

  dssm_ram #(
    .Width (dssm_pkg::WordW),
    .Depth (dssm_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .re_i    (req.re),
    .addr_i  (req.addr),
    .wdata_i (req.wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    busy_d = busy_q;
    if (fire) begin
      busy_d = 1'b1;
    end else if (adv) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold the in-flight item and the finished result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      info_q <= info;
    end
    if (adv) begin
      value_q  <= info_q.rd ? rdata : '0;
      status_q <= info_q.status;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = value_q;
  assign out_o.status = status_q;

`ifndef SYNTH
  a_hold_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !adv |-> !req.re && !req.we)
    else $error("store accessed while a result is held");
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !adv |=> busy_q)
    else $error("stalled item dropped");
  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced item not presented");
`endif

endmodule
